// ===== hw/rtl/gmsl_pkg.sv =====
// Shared types, constants and saturating helpers for the Gaussian mixture
// segment log-likelihood block. No dependencies.
package gmsl_pkg;

  localparam int MAX_COMPONENTS_DEF = 8;
  localparam int IDX_W = 3;
  localparam int CFG_W = 4;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AB;
  localparam logic [63:0] LN2_Q32 = 64'd2977044471;
  localparam logic signed [63:0] LN_2PI_Q32 = 64'sd7893621894;
  localparam logic [63:0] EXP_CUTOFF = 64'd23 << 32;
  localparam logic [63:0] ONE_Q62 = 64'd1 << 62;
  localparam logic [4:0] EXP_TERMS = 5'd24;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // Reciprocals for the Taylor term division, index is the divisor.
  localparam logic [63:0] RECIP_TBL [0:24] = '{
    64'd0,
    ALL_ONES / 64'd1,  ALL_ONES / 64'd2,  ALL_ONES / 64'd3,  ALL_ONES / 64'd4,
    ALL_ONES / 64'd5,  ALL_ONES / 64'd6,  ALL_ONES / 64'd7,  ALL_ONES / 64'd8,
    ALL_ONES / 64'd9,  ALL_ONES / 64'd10, ALL_ONES / 64'd11, ALL_ONES / 64'd12,
    ALL_ONES / 64'd13, ALL_ONES / 64'd14, ALL_ONES / 64'd15, ALL_ONES / 64'd16,
    ALL_ONES / 64'd17, ALL_ONES / 64'd18, ALL_ONES / 64'd19, ALL_ONES / 64'd20,
    ALL_ONES / 64'd21, ALL_ONES / 64'd22, ALL_ONES / 64'd23, ALL_ONES / 64'd24
  };

  typedef struct packed {
    logic              mode;
    logic [2:0]        component_index;
    logic signed [63:0] entry_mean;
    logic [62:0]       entry_sd;
    logic [32:0]       entry_weight;
    logic signed [63:0] segment_sum;
    logic [19:0]       segment_length;
    logic [62:0]       within_term;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] neg_log_likelihood;
    logic              saturated;
  } out_item_t;

  // One mixture component as held in a cell, with its cached logarithms.
  typedef struct packed {
    logic signed [63:0] mean;
    logic [62:0]       sd;
    logic [32:0]       w;
    logic signed [63:0] lnsd;
    logic signed [63:0] lnw;
    logic signed [63:0] d;
  } ent_t;

  typedef struct packed {
    logic              s;
    logic signed [63:0] v;
  } sres_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_LNW,
    ST_LD_WRITE,
    ST_MU_DIV,
    ST_C_HEAD,
    ST_C_SQ,
    ST_C_DIV1,
    ST_C_DIV2,
    ST_C_LEN,
    ST_E_HEAD,
    ST_E_RED,
    ST_E_MUL,
    ST_E_RCP,
    ST_E_REM,
    ST_E_FIX,
    ST_E_DONE,
    ST_FIN,
    ST_OUT,
    ST_LN_NORM,
    ST_LN_SQ,
    ST_LN_MUL
  } state_t;

  function automatic sres_t sat_add(logic signed [63:0] a, logic signed [63:0] b);
    sres_t r;
    logic signed [63:0] s;
    s = a + b;
    r.s = (a[63] == b[63]) && (s[63] != a[63]);
    r.v = r.s ? (b[63] ? S64_MIN : S64_MAX) : s;
    return r;
  endfunction

  function automatic sres_t sat_sub(logic signed [63:0] a, logic signed [63:0] b);
    sres_t r;
    logic signed [63:0] s;
    s = a - b;
    r.s = (a[63] != b[63]) && (s[63] != a[63]);
    r.v = r.s ? (b[63] ? S64_MAX : S64_MIN) : s;
    return r;
  endfunction

endpackage

// ===== hw/rtl/gaussian_mixture_segment_loglik.sv =====
// Top level: component ring, shared multiplier and divider, sequencer.
// Depends on gmsl_pkg, gmsl_cell, gmsl_mul and gmsl_div.
//
//   channel | handshake            | payload
//   in      | in_valid / in_stall  | in_item  (gmsl_pkg::in_item_t)
//   out     | out_valid / out_stall| out_item (gmsl_pkg::out_item_t)
//   cfg     | cfg_valid / cfg_ready| cfg_data (components_in_use)
//
// One item at a time. A load item takes two logarithms. A segment item
// takes the segment mean, then a term and an exponential for each active
// component, a shift past each idle ring cell in each pass, and the final
// logarithm, all on the shared multiplier and divider. Reset is synchronous
// and leaves the table undefined; the result register lets the next item in
// while a result waits under out_stall.
module gaussian_mixture_segment_loglik #(
  parameter int MAX_COMPONENTS = gmsl_pkg::MAX_COMPONENTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gmsl_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gmsl_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [gmsl_pkg::CFG_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_COMPONENTS + 1);

  gmsl_pkg::state_t state, state_next, ln_ret, ln_ret_next;
  logic issued, issued_next;
  logic [gmsl_pkg::CFG_W-1:0] n_use;

  logic [63:0] ln_x, ln_x_next;
  logic [5:0]  ln_k, ln_k_next;
  logic [4:0]  ln_i, ln_i_next;
  logic [31:0] ln_frac, ln_frac_next;
  logic signed [63:0] ln_res, ln_res_next;

  logic [2:0]  ld_idx, ld_idx_next;
  logic signed [63:0] ld_mean, ld_mean_next;
  logic [62:0] ld_sd, ld_sd_next;
  logic [32:0] ld_w, ld_w_next;
  logic signed [63:0] ld_lnsd, ld_lnsd_next;

  logic signed [63:0] mu, mu_next;
  logic [19:0] seg_len, seg_len_next;
  logic [62:0] seg_within, seg_within_next;
  logic        sat, sat_next;
  logic [CW-1:0] lim, lim_next, pos, pos_next;
  logic signed [63:0] best, best_next;
  logic [63:0] tmp, tmp_next;
  logic [63:0] ex_a, ex_a_next;
  logic [5:0]  ex_n, ex_n_next;
  logic [63:0] ex_sum, ex_sum_next, ex_term, ex_term_next;
  logic [4:0]  ex_k, ex_k_next;
  logic [63:0] ex_x, ex_x_next, ex_q, ex_q_next, ex_rem, ex_rem_next;
  logic [63:0] sumexp, sumexp_next;
  logic signed [63:0] res, res_next;

  logic         mul_start, mul_done;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] mul_p;
  logic         div_start, div_done, div_ovf;
  logic [127:0] div_num;
  logic [63:0]  div_den, div_q;

  logic         shift, d_wr, ld_wr, out_load;
  logic signed [63:0] d_val;

  gmsl_pkg::ent_t ring [MAX_COMPONENTS];
  gmsl_pkg::ent_t head, fb, ld_ent;

  // Arithmetic around the head cell
  gmsl_pkg::sres_t diff_r, inner_r, d_r, fin_r;
  logic [63:0] diff_mag, sq, t_sum, t_val, q_val, inner_mag, lp_l, ex_dist;
  logic        sq_ovf, q_ovf, inner_pos, lp_big, ts_sat;
  logic signed [63:0] lterm, inner, ts_v;
  logic signed [31:0] ln_kk;
  logic signed [63:0] log2q;
  logic [63:0] log2q_mag, ln_sq_m, ln_mag;
  logic signed [63:0] ln_out;

  assign head = ring[0];

  always_comb begin
    fb = head;
    if (d_wr) begin
      fb.d = d_val;
    end
  end

  assign ld_ent = '{mean: ld_mean, sd: ld_sd, w: ld_w, lnsd: ld_lnsd,
                    lnw: ln_res, d: '0};

  for (genvar i = 0; i < MAX_COMPONENTS; i++) begin : g_cell
    logic sel;
    if (i < 8) begin : g_sel
      assign sel = ld_wr && (ld_idx == 3'(i));
    end else begin : g_nosel
      assign sel = 1'b0;
    end
    if (i == MAX_COMPONENTS - 1) begin : g_last
      gmsl_cell u_cell (
        .clk(clk), .shift(shift), .wr(sel), .wr_data(ld_ent), .nb(fb), .q(ring[i])
      );
    end else begin : g_mid
      gmsl_cell u_cell (
        .clk(clk), .shift(shift), .wr(sel), .wr_data(ld_ent), .nb(ring[i+1]),
        .q(ring[i])
      );
    end
  end

  gmsl_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  gmsl_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .q(div_q), .ovf(div_ovf)
  );

  assign diff_r   = gmsl_pkg::sat_sub(mu, head.mean);
  assign diff_mag = diff_r.v[63] ? 64'(-diff_r.v) : 64'(diff_r.v);
  assign sq_ovf   = |mul_p[127:95];
  assign sq       = sq_ovf ? 64'(gmsl_pkg::S64_MAX) : mul_p[95:32];
  assign t_sum    = sq + {1'b0, seg_within};
  assign t_val    = t_sum[63] ? 64'(gmsl_pkg::S64_MAX) : t_sum;
  assign q_ovf    = div_ovf | div_q[63];
  assign q_val    = q_ovf ? 64'(gmsl_pkg::S64_MAX) : div_q;
  assign lterm    = gmsl_pkg::LN_2PI_Q32 + 64'(head.lnsd <<< 1);
  assign inner_r  = gmsl_pkg::sat_add(signed'(q_val), lterm);
  assign inner    = signed'(tmp);
  assign inner_pos = !inner[63] && (inner != 64'sd0);
  assign inner_mag = inner[63] ? 64'(-inner) : 64'(inner);
  assign lp_l     = mul_p[64:1];
  assign lp_big   = |mul_p[127:65];

  // Halved product back to signed, negated when the inner term is positive
  always_comb begin
    if (!inner_pos) begin
      ts_sat = lp_big | lp_l[63];
      ts_v   = ts_sat ? gmsl_pkg::S64_MAX : signed'(lp_l);
    end else begin
      ts_sat = lp_big | (lp_l > gmsl_pkg::TOP_BIT);
      ts_v   = (lp_big | (lp_l >= gmsl_pkg::TOP_BIT)) ? gmsl_pkg::S64_MIN
                                                       : signed'(64'(-lp_l));
    end
  end

  assign d_r     = gmsl_pkg::sat_add(ts_v, head.lnw);
  assign ex_dist = 64'(best) - 64'(head.d);
  assign fin_r   = gmsl_pkg::sat_add(best, ln_res);

  assign ln_sq_m   = mul_p[125:62];
  assign ln_kk     = 32'(signed'({26'd0, ln_k})) - 32'sd32;
  assign log2q     = {ln_kk, ln_frac};
  assign log2q_mag = log2q[63] ? 64'(-log2q) : 64'(log2q);
  assign ln_mag    = mul_p[127:64];
  assign ln_out    = log2q[63] ? signed'(64'(-ln_mag)) : signed'(ln_mag);

  assign in_stall  = (state != gmsl_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next   = state;
    issued_next  = issued;
    ln_ret_next  = ln_ret;
    ln_x_next    = ln_x;
    ln_k_next    = ln_k;
    ln_i_next    = ln_i;
    ln_frac_next = ln_frac;
    ln_res_next  = ln_res;
    ld_idx_next  = ld_idx;
    ld_mean_next = ld_mean;
    ld_sd_next   = ld_sd;
    ld_w_next    = ld_w;
    ld_lnsd_next = ld_lnsd;
    mu_next      = mu;
    seg_len_next = seg_len;
    seg_within_next = seg_within;
    sat_next     = sat;
    lim_next     = lim;
    pos_next     = pos;
    best_next    = best;
    tmp_next     = tmp;
    ex_a_next    = ex_a;
    ex_n_next    = ex_n;
    ex_sum_next  = ex_sum;
    ex_term_next = ex_term;
    ex_k_next    = ex_k;
    ex_x_next    = ex_x;
    ex_q_next    = ex_q;
    ex_rem_next  = ex_rem;
    sumexp_next  = sumexp;
    res_next     = res;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_num      = '0;
    div_den      = '0;
    shift        = 1'b0;
    d_wr         = 1'b0;
    d_val        = '0;
    ld_wr        = 1'b0;
    out_load     = 1'b0;

    unique case (state)
      gmsl_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (!in_item.mode) begin
            ld_idx_next  = in_item.component_index;
            ld_mean_next = in_item.entry_mean;
            ld_sd_next   = in_item.entry_sd;
            ld_w_next    = in_item.entry_weight;
            ln_x_next    = {1'b0, in_item.entry_sd};
            ln_k_next    = 6'd63;
            ln_ret_next  = gmsl_pkg::ST_LD_LNW;
            state_next   = gmsl_pkg::ST_LN_NORM;
          end else begin
            seg_len_next = (in_item.segment_length == '0) ? 20'd1
                                                         : in_item.segment_length;
            seg_within_next = in_item.within_term;
            mu_next      = in_item.segment_sum;
            tmp_next     = in_item.segment_sum[63] ? 64'(-in_item.segment_sum)
                                                   : 64'(in_item.segment_sum);
            sat_next     = 1'b0;
            if (n_use == '0) begin
              lim_next = CW'(1);
            end else if (32'(n_use) > MAX_COMPONENTS) begin
              lim_next = CW'(MAX_COMPONENTS);
            end else begin
              lim_next = CW'(n_use);
            end
            state_next = gmsl_pkg::ST_MU_DIV;
          end
        end
      end

      gmsl_pkg::ST_LD_LNW: begin
        ld_lnsd_next = ln_res;
        ln_x_next    = {31'd0, ld_w};
        ln_k_next    = 6'd63;
        ln_ret_next  = gmsl_pkg::ST_LD_WRITE;
        state_next   = gmsl_pkg::ST_LN_NORM;
      end

      gmsl_pkg::ST_LD_WRITE: begin
        ld_wr      = 1'b1;
        state_next = gmsl_pkg::ST_IDLE;
      end

      gmsl_pkg::ST_MU_DIV: begin
        div_num = {64'd0, tmp};
        div_den = {44'd0, seg_len};
        if (!issued) begin
          div_start   = 1'b1;
          issued_next = 1'b1;
        end else if (div_done) begin
          issued_next = 1'b0;
          mu_next     = mu[63] ? signed'(64'(-div_q)) : signed'(div_q);
          pos_next    = '0;
          best_next   = gmsl_pkg::S64_MIN;
          state_next  = gmsl_pkg::ST_C_HEAD;
        end
      end

      // First pass: one component term per active ring position
      gmsl_pkg::ST_C_HEAD: begin
        if (pos == CW'(MAX_COMPONENTS)) begin
          if (best == gmsl_pkg::S64_MIN) begin
            res_next   = gmsl_pkg::S64_MAX;
            sat_next   = 1'b1;
            state_next = gmsl_pkg::ST_OUT;
          end else begin
            pos_next    = '0;
            sumexp_next = '0;
            state_next  = gmsl_pkg::ST_E_HEAD;
          end
        end else if (pos >= lim) begin
          shift    = 1'b1;
          pos_next = pos + CW'(1);
        end else if (head.w == '0 || head.sd == '0) begin
          shift    = 1'b1;
          d_wr     = 1'b1;
          d_val    = gmsl_pkg::S64_MIN;
          sat_next = sat | (head.w != '0);
          pos_next = pos + CW'(1);
        end else begin
          sat_next   = sat | diff_r.s;
          tmp_next   = diff_mag;
          state_next = gmsl_pkg::ST_C_SQ;
        end
      end

      gmsl_pkg::ST_C_SQ: begin
        mul_a = tmp;
        mul_b = tmp;
        if (!issued) begin
          mul_start   = 1'b1;
          issued_next = 1'b1;
        end else if (mul_done) begin
          issued_next = 1'b0;
          sat_next    = sat | sq_ovf | t_sum[63];
          tmp_next    = t_val;
          state_next  = gmsl_pkg::ST_C_DIV1;
        end
      end

      gmsl_pkg::ST_C_DIV1, gmsl_pkg::ST_C_DIV2: begin
        div_num = {32'd0, tmp, 32'd0};
        div_den = {1'b0, head.sd};
        if (!issued) begin
          div_start   = 1'b1;
          issued_next = 1'b1;
        end else if (div_done) begin
          issued_next = 1'b0;
          if (state == gmsl_pkg::ST_C_DIV1) begin
            sat_next   = sat | q_ovf;
            tmp_next   = q_val;
            state_next = gmsl_pkg::ST_C_DIV2;
          end else begin
            sat_next   = sat | q_ovf | inner_r.s;
            tmp_next   = 64'(inner_r.v);
            state_next = gmsl_pkg::ST_C_LEN;
          end
        end
      end

      gmsl_pkg::ST_C_LEN: begin
        mul_a = inner_mag;
        mul_b = {44'd0, seg_len};
        if (!issued) begin
          mul_start   = 1'b1;
          issued_next = 1'b1;
        end else if (mul_done) begin
          issued_next = 1'b0;
          sat_next    = sat | ts_sat | d_r.s;
          shift       = 1'b1;
          d_wr        = 1'b1;
          d_val       = d_r.v;
          if (d_r.v > best) begin
            best_next = d_r.v;
          end
          pos_next   = pos + CW'(1);
          state_next = gmsl_pkg::ST_C_HEAD;
        end
      end

      // Second pass: sum of exp(d - best)
      gmsl_pkg::ST_E_HEAD: begin
        if (pos == CW'(MAX_COMPONENTS)) begin
          ln_x_next   = sumexp;
          ln_k_next   = 6'd63;
          ln_ret_next = gmsl_pkg::ST_FIN;
          state_next  = gmsl_pkg::ST_LN_NORM;
        end else if (pos >= lim || ex_dist >= gmsl_pkg::EXP_CUTOFF) begin
          shift    = 1'b1;
          pos_next = pos + CW'(1);
        end else begin
          ex_a_next  = ex_dist;
          ex_n_next  = '0;
          state_next = gmsl_pkg::ST_E_RED;
        end
      end

      gmsl_pkg::ST_E_RED: begin
        if (ex_a >= gmsl_pkg::LN2_Q32) begin
          ex_a_next = ex_a - gmsl_pkg::LN2_Q32;
          ex_n_next = ex_n + 6'd1;
        end else begin
          ex_a_next    = ex_a << 30;
          ex_sum_next  = gmsl_pkg::ONE_Q62;
          ex_term_next = gmsl_pkg::ONE_Q62;
          ex_k_next    = 5'd1;
          state_next   = gmsl_pkg::ST_E_MUL;
        end
      end

      gmsl_pkg::ST_E_MUL: begin
        mul_a = ex_term;
        mul_b = ex_a;
        if (!issued) begin
          mul_start   = 1'b1;
          issued_next = 1'b1;
        end else if (mul_done) begin
          issued_next = 1'b0;
          ex_x_next   = mul_p[125:62];
          state_next  = gmsl_pkg::ST_E_RCP;
        end
      end

      gmsl_pkg::ST_E_RCP: begin
        mul_a = ex_x;
        mul_b = gmsl_pkg::RECIP_TBL[ex_k];
        if (!issued) begin
          mul_start   = 1'b1;
          issued_next = 1'b1;
        end else if (mul_done) begin
          issued_next = 1'b0;
          ex_q_next   = mul_p[127:64];
          state_next  = gmsl_pkg::ST_E_REM;
        end
      end

      gmsl_pkg::ST_E_REM: begin
        ex_rem_next = ex_x - 64'(ex_q * {59'd0, ex_k});
        state_next  = gmsl_pkg::ST_E_FIX;
      end

      // Estimate runs low by a few units; step it up until exact
      gmsl_pkg::ST_E_FIX: begin
        if (ex_rem >= {59'd0, ex_k}) begin
          ex_q_next   = ex_q + 64'd1;
          ex_rem_next = ex_rem - {59'd0, ex_k};
        end else begin
          ex_term_next = ex_q;
          ex_sum_next  = ex_k[0] ? ex_sum - ex_q : ex_sum + ex_q;
          if (ex_k == gmsl_pkg::EXP_TERMS) begin
            state_next = gmsl_pkg::ST_E_DONE;
          end else begin
            ex_k_next  = ex_k + 5'd1;
            state_next = gmsl_pkg::ST_E_MUL;
          end
        end
      end

      gmsl_pkg::ST_E_DONE: begin
        sumexp_next = sumexp + (ex_sum >> (6'd30 + ex_n));
        shift       = 1'b1;
        pos_next    = pos + CW'(1);
        state_next  = gmsl_pkg::ST_E_HEAD;
      end

      gmsl_pkg::ST_FIN: begin
        sat_next   = sat | fin_r.s;
        res_next   = -fin_r.v;
        state_next = gmsl_pkg::ST_OUT;
      end

      gmsl_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = gmsl_pkg::ST_IDLE;
        end
      end

      // Logarithm: normalize, 32 squarings, scale by ln 2
      gmsl_pkg::ST_LN_NORM: begin
        if (ln_x[63] || ln_k == '0) begin
          ln_x_next  = ln_x >> 1;
          ln_i_next  = '0;
          ln_frac_next = '0;
          state_next = gmsl_pkg::ST_LN_SQ;
        end else begin
          ln_x_next = ln_x << 1;
          ln_k_next = ln_k - 6'd1;
        end
      end

      gmsl_pkg::ST_LN_SQ: begin
        mul_a = ln_x;
        mul_b = ln_x;
        if (!issued) begin
          mul_start   = 1'b1;
          issued_next = 1'b1;
        end else if (mul_done) begin
          issued_next  = 1'b0;
          ln_frac_next = {ln_frac[30:0], ln_sq_m[63]};
          ln_x_next    = ln_sq_m[63] ? (ln_sq_m >> 1) : ln_sq_m;
          ln_i_next    = ln_i + 5'd1;
          if (ln_i == 5'd31) begin
            state_next = gmsl_pkg::ST_LN_MUL;
          end
        end
      end

      gmsl_pkg::ST_LN_MUL: begin
        mul_a = log2q_mag;
        mul_b = gmsl_pkg::LN2_Q64;
        if (!issued) begin
          mul_start   = 1'b1;
          issued_next = 1'b1;
        end else if (mul_done) begin
          issued_next = 1'b0;
          ln_res_next = ln_out;
          state_next  = ln_ret;
        end
      end

      default: state_next = gmsl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gmsl_pkg::ST_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      n_use     <= gmsl_pkg::CFG_W'(1);
    end else begin
      state     <= state_next;
      issued    <= issued_next;
      out_valid <= (out_valid && out_stall) || out_load;
      if (cfg_valid && cfg_ready) begin
        n_use <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ln_ret  <= ln_ret_next;
    ln_x    <= ln_x_next;
    ln_k    <= ln_k_next;
    ln_i    <= ln_i_next;
    ln_frac <= ln_frac_next;
    ln_res  <= ln_res_next;
    ld_idx  <= ld_idx_next;
    ld_mean <= ld_mean_next;
    ld_sd   <= ld_sd_next;
    ld_w    <= ld_w_next;
    ld_lnsd <= ld_lnsd_next;
    mu      <= mu_next;
    seg_len <= seg_len_next;
    seg_within <= seg_within_next;
    sat     <= sat_next;
    lim     <= lim_next;
    pos     <= pos_next;
    best    <= best_next;
    tmp     <= tmp_next;
    ex_a    <= ex_a_next;
    ex_n    <= ex_n_next;
    ex_sum  <= ex_sum_next;
    ex_term <= ex_term_next;
    ex_k    <= ex_k_next;
    ex_x    <= ex_x_next;
    ex_q    <= ex_q_next;
    ex_rem  <= ex_rem_next;
    sumexp  <= sumexp_next;
    res     <= res_next;
    if (out_load) begin
      out_item.neg_log_likelihood <= res;
      out_item.saturated          <= sat;
    end
  end

endmodule

// ===== hw/rtl/gmsl_cell.sv =====
// One cell of the component ring: holds a mixture entry and its term.
// Depends on gmsl_pkg for the entry type.
module gmsl_cell (
  input  logic          clk,
  input  logic          shift,
  input  logic          wr,
  input  gmsl_pkg::ent_t wr_data,
  input  gmsl_pkg::ent_t nb,
  output gmsl_pkg::ent_t q
);

  always_ff @(posedge clk) begin
    if (wr) begin
      q <= wr_data;
    end else if (shift) begin
      q <= nb;
    end
  end

endmodule

// ===== hw/rtl/gmsl_mul.sv =====
// 64x64 unsigned multiplier built from four 32x32 partial products.
// Depends on nothing outside this file.
module gmsl_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] p
);

  logic [63:0]  ra;
  logic [63:0]  rb;
  logic [1:0]   step;
  logic         busy;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  pp;
  logic [127:0] term;

  assign pa = step[1] ? ra[63:32] : ra[31:0];
  assign pb = step[0] ? rb[63:32] : rb[31:0];
  assign pp = pa * pb;

  always_comb begin
    case (step)
      2'd0:    term = {64'd0, pp};
      2'd3:    term = {pp, 64'd0};
      default: term = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == 2'd3) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ra   <= a;
      rb   <= b;
      p    <= '0;
      step <= 2'd0;
    end else if (busy) begin
      p    <= p + term;
      step <= step + 2'd1;
    end
  end

endmodule

// ===== hw/rtl/gmsl_div.sv =====
// Restoring divider, 128-bit dividend by 64-bit divisor, one bit a cycle.
// Depends on nothing outside this file.
module gmsl_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic         done,
  output logic [63:0]  q,
  output logic         ovf
);

  logic [63:0] rem;
  logic [63:0] lo;
  logic [63:0] rden;
  logic [5:0]  cnt;
  logic        busy;
  logic [64:0] rem2;
  logic        take;

  assign rem2 = {rem, lo[63]};
  assign take = rem2 >= {1'b0, rden};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num[127:64];
      lo   <= num[63:0];
      rden <= den;
      ovf  <= num[127:64] >= den;
      q    <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rem <= take ? 64'(rem2 - {1'b0, rden}) : rem2[63:0];
      lo  <= {lo[62:0], 1'b0};
      q   <= {q[62:0], take};
      cnt <= cnt + 6'd1;
    end
  end

endmodule
